// ===== hw/rtl/pafp_pkg.sv =====
// Shared types, constants and the exp2 step table of the power-curve alpha fade.
// Used by every module of particle_alpha_fade_power; depends on nothing.
package pafp_pkg;

    localparam int QUEUE_DEPTH      = 4;
    localparam int QUEUE_AW         = 2;
    localparam logic [1:0] VISIBLE_INTERVAL = 2'd2;

    localparam logic [15:0] START_ALPHA_RST   = 16'd4096;
    localparam logic [15:0] FADE_EXPONENT_RST = 16'd4096;

    // configuration register indexes
    localparam logic [7:0] REG_START_ALPHA   = 8'd0;
    localparam logic [7:0] REG_FADE_EXPONENT = 8'd1;

    // input item kinds
    localparam logic REQ_PARTICLE    = 1'b0;
    localparam logic REQ_FRAME_START = 1'b1;

    // one particle as handed from front to back
    typedef struct packed {
        logic        sel;
        logic [15:0] life;
        logic [15:0] inv;
    } pafp_entry_t;

    typedef logic [31:0] pow_tab_t [16];

    function automatic logic [63:0] isqrt64(input logic [63:0] n_in);
        logic [63:0] n;
        logic [63:0] res;
        logic [63:0] bitv;
        n    = n_in;
        res  = '0;
        bitv = 64'd1 << 62;
        for (int i = 0; i < 32; i++) begin
            if (n >= res + bitv) begin
                n   = n - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // entry k holds 2^(2^-(k+1)) in Q2.30
    function automatic pow_tab_t build_pow_tab();
        pow_tab_t    t;
        logic [63:0] v;
        v    = isqrt64(64'd2 << 60);
        t[0] = v[31:0];
        for (int k = 1; k < 16; k++) begin
            v    = isqrt64(v << 30);
            t[k] = v[31:0];
        end
        return t;
    endfunction

    localparam pow_tab_t POW_TAB = build_pow_tab();

endpackage

// ===== hw/rtl/pafp_front.sv =====
// Front end: accepts items, tracks frame visibility and stride, marks selected particles.
// Depends on pafp_pkg.
module pafp_front
    import pafp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_fire,
    input  logic        req_type,
    input  logic        effect_visible,
    input  logic [15:0] life_remaining,
    input  logic [15:0] inverse_lifetime,
    output logic        push,
    output pafp_entry_t push_entry
);

    logic [1:0] next_interval_reg;
    logic [1:0] rotating_offset_reg;
    logic [1:0] frame_stride_reg;
    logic [1:0] phase_count_reg;
    logic       frame_visible_reg;
    logic [1:0] rot_inc;
    logic [1:0] stride_eff;

    assign rot_inc    = rotating_offset_reg + 2'd1;
    assign stride_eff = (frame_stride_reg == 2'd0) ? 2'd1 : frame_stride_reg;

    assign push             = in_fire && (req_type == REQ_PARTICLE);
    assign push_entry.sel   = frame_visible_reg && (phase_count_reg == 2'd0);
    assign push_entry.life  = life_remaining;
    assign push_entry.inv   = inverse_lifetime;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            next_interval_reg   <= 2'd1;
            rotating_offset_reg <= 2'd0;
            frame_stride_reg    <= 2'd1;
            phase_count_reg     <= 2'd0;
            frame_visible_reg   <= 1'b0;
        end else if (in_fire) begin
            if (req_type == REQ_FRAME_START) begin
                if (effect_visible) begin
                    frame_stride_reg    <= next_interval_reg;
                    phase_count_reg     <= rotating_offset_reg;
                    rotating_offset_reg <= (rot_inc >= next_interval_reg) ? 2'd0 : rot_inc;
                    next_interval_reg   <= VISIBLE_INTERVAL;
                    frame_visible_reg   <= 1'b1;
                end else begin
                    next_interval_reg   <= 2'd1;
                    rotating_offset_reg <= 2'd0;
                    phase_count_reg     <= 2'd0;
                    frame_visible_reg   <= 1'b0;
                end
            end else if (frame_visible_reg) begin
                if (phase_count_reg != 2'd0) begin
                    phase_count_reg <= phase_count_reg - 2'd1;
                end else begin
                    phase_count_reg <= stride_eff - 2'd1;
                end
            end
        end
    end

endmodule

// ===== hw/rtl/pafp_queue.sv =====
// Short first-in first-out queue between front and back ends.
// Depends on pafp_pkg.
module pafp_queue
    import pafp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        push,
    input  pafp_entry_t push_entry,
    input  logic        pop,
    output pafp_entry_t head,
    output logic        empty,
    output logic        full,
    output logic [QUEUE_AW:0] count
);

    pafp_entry_t         mem_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg;
    logic [QUEUE_AW-1:0] rd_ptr_reg;
    logic [QUEUE_AW:0]   count_reg;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign head  = mem_reg[rd_ptr_reg];
    assign count = count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                mem_reg[wr_ptr_reg] <= push_entry;
                wr_ptr_reg          <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== hw/rtl/pafp_back.sv =====
// Back end: fraction, up to two log2 passes on a shared unit, exponent multiply, exp2, output register.
// Depends on pafp_pkg (POW_TAB).
module pafp_back
    import pafp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [15:0] start_alpha,
    input  logic [15:0] fade_exponent,
    input  pafp_entry_t head,
    input  logic        empty,
    output logic        pop,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] alpha,
    output logic        write_alpha
);

    typedef enum logic [2:0] {
        ST_IDLE, ST_CHK, ST_LOG, ST_MUL, ST_TSUM, ST_EXP
    } state_t;

    state_t             state_reg;
    logic               out_valid_reg;
    logic [15:0]        alpha_reg;
    logic               wa_reg;
    logic [16:0]        frac_reg;
    logic               pass_reg;
    logic [16:0]        lm_reg;
    logic [4:0]         ln_reg;
    logic [15:0]        lfr_reg;
    logic [3:0]         cnt_reg;
    logic [20:0]        lsa_reg;
    logic [20:0]        lf_reg;
    logic signed [37:0] prod_reg;
    logic [31:0]        r_reg;
    logic [15:0]        f_reg;
    logic [10:0]        ip_reg;

    logic [31:0]        frac_prod;
    logic [16:0]        frac_sat;
    logic [33:0]        sq;
    logic [17:0]        sq_hi;
    logic [16:0]        lm_step;
    logic [15:0]        lfr_step;
    logic [20:0]        log_res;
    logic signed [15:0] e_s;
    logic signed [21:0] ldiff;
    logic signed [37:0] prod_c;
    logic signed [37:0] prod_adj;
    logic signed [25:0] m_val;
    logic signed [27:0] t_val;
    logic [26:0]        u_val;
    logic [63:0]        exp_prod;
    logic [31:0]        r_step;
    logic [4:0]         shamt;
    logic [31:0]        r_shift;

    function automatic logic [4:0] msb17(input logic [16:0] x);
        logic [4:0] n;
        n = '0;
        for (int i = 0; i < 17; i++) begin
            if (x[i]) n = 5'(i);
        end
        return n;
    endfunction

    function automatic logic [16:0] norm17(input logic [16:0] x);
        logic [4:0] n;
        n = msb17(x);
        return x << (5'd16 - n);
    endfunction

    assign pop       = (state_reg == ST_IDLE) && !empty && !out_valid_reg;
    assign m_tvalid  = out_valid_reg;
    assign alpha     = alpha_reg;
    assign write_alpha = wa_reg;

    assign frac_prod = head.life * head.inv;
    assign frac_sat  = (frac_prod > 32'd65536) ? 17'd65536 : frac_prod[16:0];

    // one squaring step of the log2 fraction
    assign sq       = lm_reg * lm_reg;
    assign sq_hi    = sq[33:16];
    assign lm_step  = sq_hi[17] ? sq_hi[17:1] : sq_hi[16:0];
    assign lfr_step = lfr_reg | (sq_hi[17] ? (16'd1 << cnt_reg) : 16'd0);
    assign log_res  = {ln_reg, lfr_step};

    assign e_s      = $signed(fade_exponent);
    assign ldiff    = $signed({1'b0, lf_reg}) - 22'sd1048576;
    assign prod_c   = ldiff * e_s;
    // truncate toward zero
    assign prod_adj = prod_reg + (prod_reg[37] ? 38'sd4095 : 38'sd0);
    assign m_val    = 26'(prod_adj >>> 12);
    assign t_val    = 28'(m_val) + $signed({7'd0, lsa_reg}) - 28'sd786432;
    assign u_val    = 27'(-t_val);

    assign exp_prod = r_reg * POW_TAB[4'd15 - cnt_reg];
    assign r_step   = f_reg[cnt_reg] ? exp_prod[61:30] : r_reg;
    assign shamt    = 5'd14 + ip_reg[4:0];
    assign r_shift  = r_step >> shamt;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            if (out_valid_reg && m_tready) begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (pop) begin
                        if (!head.sel) begin
                            alpha_reg     <= '0;
                            wa_reg        <= 1'b0;
                            out_valid_reg <= 1'b1;
                        end else begin
                            frac_reg  <= frac_sat;
                            state_reg <= ST_CHK;
                        end
                    end
                end
                ST_CHK: begin
                    if (start_alpha == '0) begin
                        alpha_reg     <= '0;
                        wa_reg        <= 1'b1;
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end else if (frac_reg == '0 && e_s > 16'sd0) begin
                        alpha_reg     <= '0;
                        wa_reg        <= 1'b1;
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end else if (frac_reg == '0 && e_s < 16'sd0) begin
                        alpha_reg     <= 16'hFFFF;
                        wa_reg        <= 1'b1;
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end else begin
                        lm_reg    <= norm17({1'b0, start_alpha});
                        ln_reg    <= msb17({1'b0, start_alpha});
                        lfr_reg   <= '0;
                        cnt_reg   <= 4'd15;
                        pass_reg  <= 1'b0;
                        state_reg <= ST_LOG;
                    end
                end
                ST_LOG: begin
                    lm_reg  <= lm_step;
                    lfr_reg <= lfr_step;
                    cnt_reg <= cnt_reg - 4'd1;
                    if (cnt_reg == 4'd0) begin
                        if (!pass_reg) begin
                            lsa_reg <= log_res;
                            if (frac_reg == '0) begin
                                prod_reg  <= '0;
                                state_reg <= ST_TSUM;
                            end else begin
                                lm_reg   <= norm17(frac_reg);
                                ln_reg   <= msb17(frac_reg);
                                lfr_reg  <= '0;
                                cnt_reg  <= 4'd15;
                                pass_reg <= 1'b1;
                            end
                        end else begin
                            lf_reg    <= log_res;
                            state_reg <= ST_MUL;
                        end
                    end
                end
                ST_MUL: begin
                    prod_reg  <= prod_c;
                    state_reg <= ST_TSUM;
                end
                ST_TSUM: begin
                    if (!t_val[27]) begin
                        alpha_reg     <= 16'hFFFF;
                        wa_reg        <= 1'b1;
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end else begin
                        if (u_val[15:0] != '0) begin
                            ip_reg <= u_val[26:16] + 11'd1;
                            f_reg  <= 16'd0 - u_val[15:0];
                        end else begin
                            ip_reg <= u_val[26:16];
                            f_reg  <= '0;
                        end
                        r_reg     <= 32'd1 << 30;
                        cnt_reg   <= 4'd15;
                        state_reg <= ST_EXP;
                    end
                end
                ST_EXP: begin
                    r_reg   <= r_step;
                    cnt_reg <= cnt_reg - 4'd1;
                    if (cnt_reg == 4'd0) begin
                        alpha_reg     <= (ip_reg >= 11'd17) ? 16'd0 : r_shift[15:0];
                        wa_reg        <= 1'b1;
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== hw/rtl/particle_alpha_fade_power.sv =====
// Top level of the power-curve particle alpha fade: front end, queue, back end, config registers.
// Depends on pafp_pkg, pafp_front, pafp_queue and pafp_back.
//
//  channel  | direction | ports                          | contents
//  ---------+-----------+--------------------------------+------------------------------
//  s_       | in        | s_tvalid/s_tready/tdata/tuser  | particle or frame-start item
//  m_       | out       | m_tvalid/m_tready/tdata/tuser  | one alpha per particle item
//  cfg_     | in        | cfg_valid/cfg_ready/index/data | start_alpha (0), fade_exponent (1)
//
// The front end takes one transaction per cycle while the 4-entry queue has room;
// frame-start transactions only update the selection state and produce no result.
// A particle that is not selected has its result valid in the cycle after it leaves the queue;
// a selected one passes through the shared log2 unit (two passes of 16 squaring steps)
// and the 16-step exp2 multiply loop, and skips part of them when the result saturates
// or a special case applies. The back end pops the next entry only after the result
// transaction completes. Reset (aresetn low, synchronous) empties the queue and loads the default
// registers. Holding m_tready low stalls the back end, and the input too once the queue fills.
module particle_alpha_fade_power
    import pafp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [15:0] life_remaining, [31:16] inverse_lifetime
    input  logic [1:0]  s_tuser,   // [0] req_type, [1] effect_visible
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [15:0] alpha
    output logic [0:0]  m_tuser,   // [0] write_alpha
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    logic [15:0]       start_alpha_reg;
    logic [15:0]       fade_exponent_reg;
    logic              in_fire;
    logic              push;
    pafp_entry_t       push_entry;
    pafp_entry_t       head;
    logic              pop;
    logic              q_empty;
    logic              q_full;
    logic [QUEUE_AW:0] q_count;
    logic              wa;

    // hold the item whenever the queue is full
    assign s_tready  = !q_full;
    assign in_fire   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tuser   = wa;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_alpha_reg   <= START_ALPHA_RST;
            fade_exponent_reg <= FADE_EXPONENT_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_START_ALPHA:   start_alpha_reg   <= cfg_data;
                REG_FADE_EXPONENT: fade_exponent_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    pafp_front u_front (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .in_fire          (in_fire),
        .req_type         (s_tuser[0]),
        .effect_visible   (s_tuser[1]),
        .life_remaining   (s_tdata[15:0]),
        .inverse_lifetime (s_tdata[31:16]),
        .push             (push),
        .push_entry       (push_entry)
    );

    pafp_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .empty      (q_empty),
        .full       (q_full),
        .count      (q_count)
    );

    pafp_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .start_alpha   (start_alpha_reg),
        .fade_exponent (fade_exponent_reg),
        .head          (head),
        .empty         (q_empty),
        .pop           (pop),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .alpha         (m_tdata),
        .write_alpha   (wa)
    );

    // an unwritten particle always carries zero alpha
    a_unwritten_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata == 16'd0))
        else $error("unwritten particle with nonzero alpha");

    // queue occupancy never exceeds its depth
    a_queue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        q_count <= (QUEUE_AW+1)'(QUEUE_DEPTH))
        else $error("queue overflow");

    // a frame-start transaction never enters the queue
    a_frame_no_push: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && s_tuser[0]) |-> !push)
        else $error("frame start pushed into queue");

endmodule

// ===== bench/tb_particle_alpha_fade_power.sv =====
// Self-checking bench for particle_alpha_fade_power: directed rows and special cases, then random frames.
// Depends on pafp_pkg and the RTL of particle_alpha_fade_power; predicts alpha on its own.
`timescale 1ns / 100ps

module tb_particle_alpha_fade_power;
    import pafp_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 120;

    typedef struct packed {
        logic [15:0] alpha;
        logic        write_alpha;
    } alpha_result_t;

    typedef struct {
        logic        kind;
        logic        visible;
        logic [15:0] life;
        logic [15:0] inv;
        logic        has_value;
        logic [15:0] alpha;
        logic        write_alpha;
    } stim_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic [0:0]  m_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;

    particle_alpha_fade_power dut (.*);

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // predictor state
    logic [15:0] sa_reg, exp_reg;
    logic [1:0]  nxt_int, rot_off, frm_stride, phase;
    logic        frm_vis;
    logic [63:0] exp2_steps [16];

    alpha_result_t expected_alphas [$];
    int  errors = 0;
    int  pct_send_idle = 0, pct_recv_idle = 0;
    bit  hold_recv = 1'b0;
    int  n_results = 0, n_written = 0, n_items = 0;
    longint cycles = 0;

    function automatic logic [63:0] root64(input logic [63:0] val);
        logic [63:0] rem, acc, b;
        rem = val;
        acc = '0;
        b   = 64'd1 << 62;
        while (b > rem) b = b >> 2;
        while (b != 0) begin
            if (rem >= acc + b) begin
                rem = rem - (acc + b);
                acc = (acc >> 1) + b;
            end else begin
                acc = acc >> 1;
            end
            b = b >> 2;
        end
        return acc;
    endfunction

    function automatic longint log2_fix(input logic [31:0] x);
        int     lead;
        logic [31:0] t;
        logic [63:0] mant;
        longint frac_bits;
        lead = 0;
        t    = x;
        frac_bits = 0;
        while (t > 1) begin
            t = t >> 1;
            lead++;
        end
        mant = 64'(x) << (16 - lead);
        for (int i = 15; i >= 0; i--) begin
            mant = (mant * mant) >> 16;
            if (mant >= 64'd131072) begin
                mant = mant >> 1;
                frac_bits |= longint'(1) << i;
            end
        end
        return longint'(lead) * 65536 + frac_bits;
    endfunction

    function automatic logic [15:0] power_alpha(input logic [31:0] frac, input logic [15:0] sa,
                                                input logic signed [15:0] ex);
        longint prod_l, sum_l;
        logic [63:0] mag, whole, part, fr, acc, sh;
        if (sa == 0) return 16'd0;
        if (frac == 0) begin
            if (ex > 0) return 16'd0;
            if (ex < 0) return 16'hFFFF;
            prod_l = 0;
        end else begin
            prod_l = ((log2_fix(frac) - longint'(16) * 65536) * longint'(ex)) / 4096;
        end
        sum_l = prod_l + log2_fix({16'd0, sa}) - longint'(12) * 65536;
        if (sum_l >= 0) return 16'hFFFF;
        mag   = 64'(-sum_l);
        whole = mag >> 16;
        part  = mag & 64'hFFFF;
        if (part != 0) begin
            whole++;
            fr = 64'd65536 - part;
        end else begin
            fr = 0;
        end
        acc = 64'd1 << 30;
        for (int b = 15; b >= 0; b--)
            if (fr[b]) acc = (acc * exp2_steps[15 - b]) >> 30;
        sh = 64'd14 + whole;
        if (sh >= 63) return 16'd0;
        return 16'(acc >> sh);
    endfunction

    // Advance the selection state for one accepted item; queue a result for particles.
    task automatic predict_item(input logic kind, input logic vis, input logic [15:0] life,
                                input logic [15:0] inv);
        alpha_result_t r;
        logic [31:0] prod, frac;
        logic [1:0]  stride;
        r = '0;
        if (kind == REQ_FRAME_START) begin
            if (vis) begin
                frm_stride = nxt_int;
                phase      = rot_off;
                rot_off    = rot_off + 2'd1;
                if (rot_off >= nxt_int) rot_off = 2'd0;
                nxt_int    = VISIBLE_INTERVAL;
                frm_vis    = 1'b1;
            end else begin
                nxt_int = 2'd1;
                rot_off = 2'd0;
                phase   = 2'd0;
                frm_vis = 1'b0;
            end
            return;
        end
        if (frm_vis && phase != 0) begin
            phase = phase - 2'd1;
        end else if (frm_vis) begin
            stride = (frm_stride == 0) ? 2'd1 : frm_stride;
            phase  = stride - 2'd1;
            prod   = life * inv;
            frac   = (prod > 32'd65536) ? 32'd65536 : prod;
            r.alpha       = power_alpha(frac, sa_reg, exp_reg);
            r.write_alpha = 1'b1;
        end
        expected_alphas.push_back(r);
    endtask

    // Hold valid until the transaction completes; drop it only while idling.
    task automatic send_item(input logic kind, input logic vis, input logic [15:0] life,
                             input logic [15:0] inv);
        while ($urandom_range(99) < pct_send_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= {vis, kind};
        s_tdata  <= {inv, life};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_item(kind, vis, life, inv);
        n_items++;
    endtask

    task automatic write_reg(input logic [7:0] idx, input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        @(posedge aclk);
        if (idx == REG_START_ALPHA) sa_reg = val;
        else exp_reg = val;
    endtask

    // Wait out the queue, then let a trailing unselected particle settle.
    task automatic drain_block();
        s_tvalid <= 1'b0;
        while (expected_alphas.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Receiver: random stalls, plus a long hold-off on request.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= !hold_recv && ($urandom_range(99) >= pct_recv_idle);
        end
    end

    // Compare each result transaction with the oldest expectation.
    always @(posedge aclk) begin
        alpha_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_alphas.size() == 0) begin
                $display("%0t: unexpected result alpha=%h write=%b", $time, m_tdata, m_tuser);
                errors++;
            end else begin
                want = expected_alphas.pop_front();
                n_results++;
                if (want.write_alpha) n_written++;
                if (m_tdata !== want.alpha) begin
                    $display("%0t: alpha expected %h actual %h", $time, want.alpha, m_tdata);
                    errors++;
                end
                if (m_tuser[0] !== want.write_alpha) begin
                    $display("%0t: write_alpha expected %b actual %b", $time,
                             want.write_alpha, m_tuser[0]);
                    errors++;
                end
            end
        end
    end

    // Timeout watchdog.
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // A random sequence: mostly visible frames with a few particles each, some hidden.
    task automatic random_phase(input int n);
        int sent;
        logic [15:0] life, inv;
        sent = 0;
        while (sent < n) begin
            if ($urandom_range(9) < 8) begin
                send_item(REQ_FRAME_START, $urandom_range(5) != 0, 16'($urandom), 16'($urandom));
                repeat ($urandom_range(1, 6)) begin
                    case ($urandom_range(3))
                        0: begin life = 16'($urandom); inv = 16'($urandom); end
                        1: begin
                            life = 16'($urandom_range(1, 511));
                            inv  = 16'($urandom_range(1, 511));
                        end
                        2: begin life = 16'($urandom_range(0, 3)); inv = 16'($urandom); end
                        default: begin
                            life = 16'($urandom_range(1, 255));
                            inv  = 16'($urandom_range(0, 300));
                        end
                    endcase
                    send_item(REQ_PARTICLE, 1'($urandom_range(1)), life, inv);
                    sent++;
                end
            end else begin
                send_item(REQ_PARTICLE, 1'($urandom_range(1)), 16'($urandom), 16'($urandom));
                sent++;
            end
        end
    endtask

    stim_row_t directed [$];

    task automatic add_row(input logic k, input logic v, input logic [15:0] l, input logic [15:0] i,
                           input logic hv, input logic [15:0] a, input logic w);
        stim_row_t row;
        row = '{k, v, l, i, hv, a, w};
        directed.push_back(row);
    endtask

    initial begin
        logic [63:0] v;
        int lp;
        v = root64(64'd2 << 60);
        exp2_steps[0] = v;
        for (int k = 1; k < 16; k++) begin
            v = root64(exp2_steps[k - 1] << 30);
            exp2_steps[k] = v;
        end
        sa_reg = START_ALPHA_RST;  exp_reg = FADE_EXPONENT_RST;
        nxt_int = 2'd1; rot_off = 2'd0; frm_stride = 2'd1; phase = 2'd0; frm_vis = 1'b0;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed rows: no frame yet, hidden, visible with stride 1 and then 2, extremes.
        add_row(REQ_PARTICLE,    1, 16'hFFFF, 16'hFFFF, 1, 16'd0, 0);
        add_row(REQ_FRAME_START, 0, 16'hFFFF, 16'hFFFF, 0, 0, 0);
        add_row(REQ_PARTICLE,    0, 16'd256, 16'd256, 1, 16'd0, 0);
        add_row(REQ_FRAME_START, 1, 16'd0, 16'd0, 0, 0, 0);
        add_row(REQ_PARTICLE,    0, 16'hFFFF, 16'hFFFF, 1, 16'hFFFF, 1);
        add_row(REQ_PARTICLE,    1, 16'd0, 16'hFFFF, 1, 16'd0, 1);
        add_row(REQ_PARTICLE,    0, 16'd128, 16'd256, 0, 0, 0);
        add_row(REQ_FRAME_START, 1, 16'd0, 16'd0, 0, 0, 0);
        add_row(REQ_PARTICLE,    0, 16'd100, 16'd300, 0, 0, 0);
        add_row(REQ_PARTICLE,    0, 16'd100, 16'd300, 1, 16'd0, 0);
        add_row(REQ_PARTICLE,    0, 16'd1, 16'd1, 0, 0, 0);
        add_row(REQ_FRAME_START, 1, 16'd0, 16'd0, 0, 0, 0);
        add_row(REQ_PARTICLE,    0, 16'd1, 16'd1, 0, 0, 0);
        add_row(REQ_PARTICLE,    0, 16'd40, 16'd900, 0, 0, 0);
        add_row(REQ_PARTICLE,    0, 16'd200, 16'd200, 0, 0, 0);
        add_row(REQ_FRAME_START, 0, 16'd0, 16'd0, 0, 0, 0);
        add_row(REQ_FRAME_START, 1, 16'd0, 16'd0, 0, 0, 0);
        add_row(REQ_PARTICLE,    0, 16'd0, 16'd0, 1, 16'd0, 1);
        add_row(REQ_PARTICLE,    0, 16'd3, 16'd7, 0, 0, 0);

        pct_send_idle = 22; pct_recv_idle = 79;
        foreach (directed[j]) begin
            send_item(directed[j].kind, directed[j].visible, directed[j].life, directed[j].inv);
            // Override the prediction with the typed value where the row has one.
            if (directed[j].kind == REQ_PARTICLE && directed[j].has_value) begin
                expected_alphas[expected_alphas.size() - 1] =
                    '{directed[j].alpha, directed[j].write_alpha};
            end
        end
        drain_block();

        // Zero fraction with a zero and a negative exponent, zero scale, maximum scale.
        write_reg(REG_FADE_EXPONENT, 16'd0);
        write_reg(REG_START_ALPHA, 16'hFFFF);
        send_item(REQ_FRAME_START, 0, 0, 0);
        send_item(REQ_FRAME_START, 1, 0, 0);
        send_item(REQ_PARTICLE, 0, 16'd0, 16'd77);
        expected_alphas[expected_alphas.size() - 1] = '{16'hFFFF, 1'b1};
        drain_block();
        write_reg(REG_FADE_EXPONENT, 16'h8000);
        send_item(REQ_FRAME_START, 0, 0, 0);
        send_item(REQ_FRAME_START, 1, 0, 0);
        send_item(REQ_PARTICLE, 0, 16'd5, 16'd0);
        expected_alphas[expected_alphas.size() - 1] = '{16'hFFFF, 1'b1};
        send_item(REQ_PARTICLE, 0, 16'd12, 16'd34);
        drain_block();
        write_reg(REG_START_ALPHA, 16'd0);
        send_item(REQ_FRAME_START, 0, 0, 0);
        send_item(REQ_FRAME_START, 1, 0, 0);
        send_item(REQ_PARTICLE, 0, 16'd90, 16'd90);
        expected_alphas[expected_alphas.size() - 1] = '{16'd0, 1'b1};
        drain_block();

        // Random phases, each under its own register setting and one of three idling mixes.
        for (lp = 0; lp < 6; lp++) begin
            case (lp)
                0: begin
                    write_reg(REG_START_ALPHA, 16'd4096);
                    write_reg(REG_FADE_EXPONENT, 16'h7FFF);
                end
                1: begin write_reg(REG_START_ALPHA, 16'd1); write_reg(REG_FADE_EXPONENT, 16'd1); end
                2: begin
                    write_reg(REG_START_ALPHA, 16'($urandom));
                    write_reg(REG_FADE_EXPONENT, 16'($urandom));
                end
                3: begin
                    write_reg(REG_START_ALPHA, 16'd2048);
                    write_reg(REG_FADE_EXPONENT, 16'd2048);
                end
                4: begin write_reg(REG_START_ALPHA, 16'($urandom_range(1, 8191)));
                          write_reg(REG_FADE_EXPONENT, 16'($urandom_range(0, 20000))); end
                default: begin write_reg(REG_START_ALPHA, 16'd4096);
                               write_reg(REG_FADE_EXPONENT, 16'($urandom)); end
            endcase
            if (lp < 2) begin pct_send_idle = 22; pct_recv_idle = 79; end
            else if (lp < 4) begin pct_send_idle = 79; pct_recv_idle = 22; end
            else begin pct_send_idle = 0; pct_recv_idle = 0; end
            if (lp == 4) begin
                // Hold the receiver off long enough for the queue to fill and stall the input.
                fork
                    begin
                        hold_recv = 1'b1;
                        repeat (600) @(posedge aclk);
                        hold_recv = 1'b0;
                    end
                    random_phase(62);
                join
            end else begin
                random_phase(62);
            end
            drain_block();
        end

        $display("Sent %0d items; checked %0d particle results, %0d with alpha written.",
                 n_items, n_results, n_written);
        $display("Register settings covered zero, unit and extreme scales and exponents.");
        if (errors == 0 && expected_alphas.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/pafp_pkg.sv
hw/rtl/pafp_front.sv
hw/rtl/pafp_queue.sv
hw/rtl/pafp_back.sv
hw/rtl/particle_alpha_fade_power.sv
bench/tb_particle_alpha_fade_power.sv
